// ===== rtl/dbd_pkg.sv =====
// ----------------------------------------------------------------------------
// dbd_pkg
// Types and constants shared by the detection box decoder.
// ----------------------------------------------------------------------------
package dbd_pkg;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 13;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_THRESHOLD    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_IMAGE_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_IMAGE_HEIGHT = 2'd2;

  localparam logic [8:0]  THRESHOLD_RESET = 9'd128;
  localparam logic [12:0] IMAGE_SIZE_RESET = 13'd640;

  // Elements ahead of the class scores: cx, cy, w, h.
  localparam int BOX_ELEMENTS = 4;

  // Quotients of the back end fit in this many bits.
  localparam int QUOT_W = 24;

  typedef struct packed {
    logic signed [19:0] element_value;
    logic               last_element;
  } in_item_t;

  typedef struct packed {
    logic [11:0] box_x;
    logic [11:0] box_y;
    logic [12:0] box_width;
    logic [12:0] box_height;
    logic [7:0]  class_index;
    logic [18:0] best_score_out;
  } out_item_t;

  typedef struct packed {
    logic [8:0]  conf_threshold;
    logic [12:0] image_width;
    logic [12:0] image_height;
  } cfg_t;

  typedef struct packed {
    logic signed [19:0] cx;
    logic signed [19:0] cy;
    logic signed [19:0] w;
    logic signed [19:0] h;
    logic [18:0]        score;
    logic [7:0]         cls;
    logic [12:0]        size_w;
    logic [12:0]        size_h;
  } job_t;

endpackage

// ===== rtl/dbd_fifo.sv =====
// ----------------------------------------------------------------------------
// dbd_fifo
// Small register queue with first-word fall-through.
// ----------------------------------------------------------------------------
module dbd_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             rd,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wp_r, wp_nxt;
  logic [PTR_W-1:0] rp_r, rp_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_wr, do_rd;

  assign full  = (cnt_r == CNT_W'(DEPTH));
  assign empty = (cnt_r == '0);
  assign do_wr = wr && !full;
  assign do_rd = rd && !empty;
  assign dout  = mem[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (do_wr) begin
      wp_nxt = (wp_r == PTR_W'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
    end
    if (do_rd) begin
      rp_nxt = (rp_r == PTR_W'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wp_r] <= din;
    end
  end

`ifndef ASSERT_OFF
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(DEPTH))
    else $error("queue count beyond depth");

  a_cnt_inc: assert property (@(posedge clk) disable iff (!rst_n)
    (do_wr && !do_rd) |=> cnt_r == $past(cnt_r) + 1'b1)
    else $error("queue count did not advance on write");

  a_cnt_dec: assert property (@(posedge clk) disable iff (!rst_n)
    (do_rd && !do_wr) |=> cnt_r == $past(cnt_r) - 1'b1)
    else $error("queue count did not drop on read");
`endif

endmodule

// ===== rtl/dbd_front.sv =====
// ----------------------------------------------------------------------------
// dbd_front
// Latches box elements, tracks the best class score and issues a decode job
// at the last element of a prediction whose score passes the threshold.
// ----------------------------------------------------------------------------
module dbd_front #(
  parameter int MAX_CLASSES    = 80,
  parameter int MAX_IMAGE_SIZE = 4096
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_fire,
  input  dbd_pkg::in_item_t in_item,
  input  dbd_pkg::cfg_t     cfg,
  output logic              job_push,
  output dbd_pkg::job_t     job
);

  localparam logic [8:0] IDX_MAX = 9'd511;

  logic [8:0]         idx_r, idx_nxt;
  logic signed [19:0] cx_r, cx_nxt;
  logic signed [19:0] cy_r, cy_nxt;
  logic signed [19:0] w_r, w_nxt;
  logic signed [19:0] h_r, h_nxt;
  logic [18:0]        best_r, best_nxt;
  logic [7:0]         cls_r, cls_nxt;
  logic [9:0]         cls_off;
  logic               is_score;
  logic               better;
  logic signed [19:0] v;

  assign v        = in_item.element_value;
  assign cls_off  = {1'b0, idx_r} - 10'(dbd_pkg::BOX_ELEMENTS);
  assign is_score = (idx_r >= 9'(dbd_pkg::BOX_ELEMENTS)) && (cls_off < 10'(MAX_CLASSES));
  assign better   = !v[19] && (v[18:0] > best_r);

  always_comb begin
    cx_nxt   = cx_r;
    cy_nxt   = cy_r;
    w_nxt    = w_r;
    h_nxt    = h_r;
    best_nxt = best_r;
    cls_nxt  = cls_r;
    case (idx_r)
      9'd0:    cx_nxt = v;
      9'd1:    cy_nxt = v;
      9'd2:    w_nxt  = v;
      9'd3:    h_nxt  = v;
      default: begin
        if (is_score && better) begin
          best_nxt = v[18:0];
          cls_nxt  = cls_off[7:0];
        end
      end
    endcase
    idx_nxt = (idx_r == IDX_MAX) ? idx_r : idx_r + 1'b1;
  end

  always_comb begin
    job.cx     = cx_nxt;
    job.cy     = cy_nxt;
    job.w      = w_nxt;
    job.h      = h_nxt;
    job.score  = best_nxt;
    job.cls    = cls_nxt;
    job.size_w = (cfg.image_width > 13'(MAX_IMAGE_SIZE)) ? 13'(MAX_IMAGE_SIZE)
                                                         : cfg.image_width;
    job.size_h = (cfg.image_height > 13'(MAX_IMAGE_SIZE)) ? 13'(MAX_IMAGE_SIZE)
                                                          : cfg.image_height;
  end

  assign job_push = in_fire && in_item.last_element &&
                    (best_nxt > {10'b0, cfg.conf_threshold});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r  <= '0;
      cx_r   <= '0;
      cy_r   <= '0;
      w_r    <= '0;
      h_r    <= '0;
      best_r <= '0;
      cls_r  <= '0;
    end else if (in_fire) begin
      cx_r <= cx_nxt;
      cy_r <= cy_nxt;
      w_r  <= w_nxt;
      h_r  <= h_nxt;
      if (in_item.last_element) begin
        idx_r  <= '0;
        best_r <= '0;
        cls_r  <= '0;
      end else begin
        idx_r  <= idx_nxt;
        best_r <= best_nxt;
        cls_r  <= cls_nxt;
      end
    end
  end

endmodule

// ===== rtl/dbd_back.sv =====
// ----------------------------------------------------------------------------
// dbd_back
// Four-stage decode pipeline: magnitude products, reciprocal division by the
// model size, corner clamp, extent trim. Failing boxes are dropped.
// ----------------------------------------------------------------------------
module dbd_back #(
  parameter int MODEL_SIZE = 640
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               job_valid,
  input  dbd_pkg::job_t      job,
  output logic               job_pop,
  output logic               res_valid,
  output dbd_pkg::out_item_t res,
  input  logic               res_full
);

  localparam int QW      = dbd_pkg::QUOT_W;
  localparam int SHIFT   = QW + $clog2(MODEL_SIZE);
  localparam int RW      = QW + 1;
  localparam longint unsigned RECIP =
    ((64'd1 << SHIFT) + 64'(MODEL_SIZE) - 64'd1) / 64'(MODEL_SIZE);
  localparam logic [RW-1:0] RECIP_V = RW'(RECIP);

  function automatic logic [QW-1:0] div_model(input logic [QW-1:0] a);
    logic [QW+RW-1:0] p;
    p = {{RW{1'b0}}, a} * {{QW{1'b0}}, RECIP_V};
    return QW'(p >> SHIFT);
  endfunction

  logic adv;

  // stage 1
  logic signed [21:0] dx, dy;
  logic [20:0]        mdx, mdy;
  logic [19:0]        mw, mh;
  logic [33:0]        pdx, pdy;
  logic [32:0]        pw, ph;
  logic               s1_v_r;
  logic [QW-1:0]      s1_ax_r, s1_ay_r, s1_aw_r, s1_ah_r;
  logic               s1_xn_r, s1_yn_r, s1_wn_r, s1_hn_r;
  logic [12:0]        s1_sw_r, s1_sh_r;
  logic [7:0]         s1_cls_r;
  logic [18:0]        s1_sc_r;

  // stage 2
  logic               s2_v_r;
  logic [QW-1:0]      s2_qx_r, s2_qy_r, s2_qw_r, s2_qh_r;
  logic               s2_xn_r, s2_yn_r, s2_wn_r, s2_hn_r;
  logic [12:0]        s2_sw_r, s2_sh_r;
  logic [7:0]         s2_cls_r;
  logic [18:0]        s2_sc_r;

  // stage 3
  logic [12:0]        lim_w, lim_h;
  logic [11:0]        px_nxt, py_nxt;
  logic               ok_nxt;
  logic               s3_v_r, s3_ok_r;
  logic [11:0]        s3_px_r, s3_py_r;
  logic [QW-1:0]      s3_qw_r, s3_qh_r;
  logic [12:0]        s3_sw_r, s3_sh_r;
  logic [7:0]         s3_cls_r;
  logic [18:0]        s3_sc_r;

  // stage 4
  logic [12:0]        room_w, room_h;
  dbd_pkg::out_item_t s4_nxt;
  logic               s4_v_r;
  dbd_pkg::out_item_t s4_r;

  assign adv     = !s4_v_r || !res_full;
  assign job_pop = adv && job_valid;

  assign dx  = $signed({job.cx[19], job.cx, 1'b0}) - $signed({{2{job.w[19]}}, job.w});
  assign dy  = $signed({job.cy[19], job.cy, 1'b0}) - $signed({{2{job.h[19]}}, job.h});
  assign mdx = dx[21] ? 21'(-dx) : dx[20:0];
  assign mdy = dy[21] ? 21'(-dy) : dy[20:0];
  assign mw  = job.w[19] ? 20'(-job.w) : job.w;
  assign mh  = job.h[19] ? 20'(-job.h) : job.h;
  assign pdx = {13'b0, mdx} * {21'b0, job.size_w};
  assign pdy = {13'b0, mdy} * {21'b0, job.size_h};
  assign pw  = {13'b0, mw} * {20'b0, job.size_w};
  assign ph  = {13'b0, mh} * {20'b0, job.size_h};

  assign lim_w  = s2_sw_r - 13'd1;
  assign lim_h  = s2_sh_r - 13'd1;
  assign px_nxt = s2_xn_r ? 12'd0 : (s2_qx_r > QW'(lim_w)) ? lim_w[11:0] : s2_qx_r[11:0];
  assign py_nxt = s2_yn_r ? 12'd0 : (s2_qy_r > QW'(lim_h)) ? lim_h[11:0] : s2_qy_r[11:0];
  assign ok_nxt = !s2_wn_r && (s2_qw_r != '0) && !s2_hn_r && (s2_qh_r != '0);

  assign room_w = s3_sw_r - {1'b0, s3_px_r};
  assign room_h = s3_sh_r - {1'b0, s3_py_r};

  always_comb begin
    s4_nxt.box_x          = s3_px_r;
    s4_nxt.box_y          = s3_py_r;
    s4_nxt.box_width      = (s3_qw_r > QW'(room_w)) ? room_w : s3_qw_r[12:0];
    s4_nxt.box_height     = (s3_qh_r > QW'(room_h)) ? room_h : s3_qh_r[12:0];
    s4_nxt.class_index    = s3_cls_r;
    s4_nxt.best_score_out = s3_sc_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r <= job_valid;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
      s4_v_r <= s3_v_r && s3_ok_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_ax_r  <= pdx[32:9];
      s1_ay_r  <= pdy[32:9];
      s1_aw_r  <= pw[31:8];
      s1_ah_r  <= ph[31:8];
      s1_xn_r  <= dx[21];
      s1_yn_r  <= dy[21];
      s1_wn_r  <= job.w[19];
      s1_hn_r  <= job.h[19];
      s1_sw_r  <= job.size_w;
      s1_sh_r  <= job.size_h;
      s1_cls_r <= job.cls;
      s1_sc_r  <= job.score;

      s2_qx_r  <= div_model(s1_ax_r);
      s2_qy_r  <= div_model(s1_ay_r);
      s2_qw_r  <= div_model(s1_aw_r);
      s2_qh_r  <= div_model(s1_ah_r);
      s2_xn_r  <= s1_xn_r;
      s2_yn_r  <= s1_yn_r;
      s2_wn_r  <= s1_wn_r;
      s2_hn_r  <= s1_hn_r;
      s2_sw_r  <= s1_sw_r;
      s2_sh_r  <= s1_sh_r;
      s2_cls_r <= s1_cls_r;
      s2_sc_r  <= s1_sc_r;

      s3_px_r  <= px_nxt;
      s3_py_r  <= py_nxt;
      s3_ok_r  <= ok_nxt;
      s3_qw_r  <= s2_qw_r;
      s3_qh_r  <= s2_qh_r;
      s3_sw_r  <= s2_sw_r;
      s3_sh_r  <= s2_sh_r;
      s3_cls_r <= s2_cls_r;
      s3_sc_r  <= s2_sc_r;

      s4_r     <= s4_nxt;
    end
  end

  assign res_valid = s4_v_r;
  assign res       = s4_r;

`ifndef ASSERT_OFF
  a_res_extent: assert property (@(posedge clk) disable iff (!rst_n)
    s4_v_r |-> (s4_r.box_width != '0) && (s4_r.box_height != '0))
    else $error("box with empty extent reached the output");

  a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s4_v_r && res_full) |=> s4_v_r && $stable(s4_r))
    else $error("stalled result changed");

  a_ok_forward: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && s3_v_r && s3_ok_r) |=> s4_v_r)
    else $error("passing box lost between trim and output");
`endif

endmodule

// ===== rtl/detection_box_decode_top.sv =====
// ----------------------------------------------------------------------------
// detection_box_decode_top
// Streaming decoder of one detector prediction into a clamped image box.
// ----------------------------------------------------------------------------
// Throughput: one element per cycle while the job queue is not full; the front
//   end updates its running state in the cycle an element is taken.
// Path: a box reaches the result ports from its last element through the job
//   queue, the four back-end stages and the result queue.
// Reset: synchronous, active low; clears state and queues, restores threshold
//   128 and image size 640 x 640.
// ----------------------------------------------------------------------------
module detection_box_decode_top #(
  parameter int MAX_CLASSES    = 80,
  parameter int MODEL_SIZE     = 640,
  parameter int MAX_IMAGE_SIZE = 4096
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_push,
  output logic                              in_full,
  input  dbd_pkg::in_item_t                 in_data,
  output logic                              out_empty,
  input  logic                              out_pop,
  output dbd_pkg::out_item_t                out_data,
  input  logic                              cfg_wr_en,
  input  logic [dbd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [dbd_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  localparam int JOB_DEPTH = 4;
  localparam int OUT_DEPTH = 2;

  dbd_pkg::cfg_t      cfg_r;
  logic               in_fire;
  logic               job_push;
  dbd_pkg::job_t      job_in;
  dbd_pkg::job_t      job_out;
  logic               jq_full, jq_empty;
  logic               job_pop;
  logic               res_valid;
  dbd_pkg::out_item_t res;
  logic               oq_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.conf_threshold <= dbd_pkg::THRESHOLD_RESET;
      cfg_r.image_width    <= dbd_pkg::IMAGE_SIZE_RESET;
      cfg_r.image_height   <= dbd_pkg::IMAGE_SIZE_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        dbd_pkg::CFG_IDX_THRESHOLD:    cfg_r.conf_threshold <= cfg_wdata[8:0];
        dbd_pkg::CFG_IDX_IMAGE_WIDTH:  cfg_r.image_width    <= cfg_wdata;
        dbd_pkg::CFG_IDX_IMAGE_HEIGHT: cfg_r.image_height   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign in_full = jq_full;
  assign in_fire = in_push && !jq_full;

  dbd_front #(
    .MAX_CLASSES    (MAX_CLASSES),
    .MAX_IMAGE_SIZE (MAX_IMAGE_SIZE)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_fire),
    .in_item  (in_data),
    .cfg      (cfg_r),
    .job_push (job_push),
    .job      (job_in)
  );

  dbd_fifo #(
    .WIDTH ($bits(dbd_pkg::job_t)),
    .DEPTH (JOB_DEPTH)
  ) u_job_q (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (job_push),
    .din   (job_in),
    .full  (jq_full),
    .rd    (job_pop),
    .dout  (job_out),
    .empty (jq_empty)
  );

  dbd_back #(
    .MODEL_SIZE (MODEL_SIZE)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (!jq_empty),
    .job       (job_out),
    .job_pop   (job_pop),
    .res_valid (res_valid),
    .res       (res),
    .res_full  (oq_full)
  );

  dbd_fifo #(
    .WIDTH ($bits(dbd_pkg::out_item_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (res_valid),
    .din   (res),
    .full  (oq_full),
    .rd    (out_pop),
    .dout  (out_data),
    .empty (out_empty)
  );

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for detection_box_decode_top. Prediction elements are
// streamed through the push/full port and every kept box is predicted here
// and compared field by field with the beats popped from the result port.
// Runs through threshold and image-size settings, including the extremes,
// with random gaps and one long result-side stall.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_CLASSES    = 80;
  localparam int MODEL_SIZE     = 640;
  localparam int MAX_IMAGE_SIZE = 4096;
  localparam int POS_MAX        = 511;
  localparam int DRAIN_CYCLES   = 10;
  localparam int RX_HOLD_CYCLES = 400;
  localparam int STALL_LIMIT    = 5000;

  logic                           clk       = 1'b0;
  logic                           rst_n     = 1'b0;
  logic                           in_push   = 1'b0;
  logic                           in_full;
  dbd_pkg::in_item_t              in_data   = '0;
  logic                           out_empty;
  logic                           out_pop   = 1'b0;
  dbd_pkg::out_item_t             out_data;
  logic                           cfg_wr_en = 1'b0;
  logic [dbd_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [dbd_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  dbd_pkg::in_item_t  element_queue[$];
  dbd_pkg::out_item_t expected_boxes[$];

  // decoder state and register copies
  logic [8:0]         elem_pos;
  logic signed [19:0] cx_q, cy_q, w_q, h_q;
  logic signed [19:0] best_score;
  logic [7:0]         best_class;
  logic [8:0]         thr_cfg;
  logic [12:0]        img_w_cfg, img_h_cfg;

  int errors        = 0;
  int idle_run      = 0;
  int tx_gap        = 0;
  int rx_gap        = 0;
  int hold_left     = 0;
  int hold_requests = 0;
  int hold_served   = 0;
  bit tx_idle_on    = 1'b1;
  bit rx_idle_on    = 1'b1;

  detection_box_decode_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_data   (in_data),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #1 clk = ~clk;

  function automatic longint clip_size(input logic [12:0] s);
    return (s > MAX_IMAGE_SIZE) ? longint'(MAX_IMAGE_SIZE) : longint'(s);
  endfunction

  function automatic bit scale_axis(input longint c, input longint e, input longint sz,
                                    output longint pos, output longint len);
    pos = ((2 * c - e) * sz) / (512 * MODEL_SIZE);
    len = (e * sz) / (256 * MODEL_SIZE);
    if (pos > sz - 1) pos = sz - 1;
    if (pos < 0) pos = 0;
    if (len > sz - pos) len = sz - pos;
    return len > 0;
  endfunction

  task automatic decode_element(input dbd_pkg::in_item_t it);
    dbd_pkg::out_item_t box;
    longint             x, y, bw, bh;
    bit                 okx, oky;
    case (elem_pos)
      9'd0: cx_q = it.element_value;
      9'd1: cy_q = it.element_value;
      9'd2: w_q  = it.element_value;
      9'd3: h_q  = it.element_value;
      default: begin
        if (int'(elem_pos) - dbd_pkg::BOX_ELEMENTS < MAX_CLASSES &&
            it.element_value > best_score) begin
          best_score = it.element_value;
          best_class = 8'(int'(elem_pos) - dbd_pkg::BOX_ELEMENTS);
        end
      end
    endcase
    if (elem_pos < POS_MAX) elem_pos = elem_pos + 9'd1;
    if (it.last_element) begin
      if (longint'(best_score) > longint'(thr_cfg)) begin
        okx = scale_axis(cx_q, w_q, clip_size(img_w_cfg), x, bw);
        oky = scale_axis(cy_q, h_q, clip_size(img_h_cfg), y, bh);
        if (okx && oky) begin
          box.box_x          = 12'(x);
          box.box_y          = 12'(y);
          box.box_width      = 13'(bw);
          box.box_height     = 13'(bh);
          box.class_index    = best_class;
          box.best_score_out = 19'(best_score);
          expected_boxes = {expected_boxes, box};
        end
      end
      elem_pos   = '0;
      best_score = '0;
      best_class = '0;
    end
  endtask

  task automatic check_box(input dbd_pkg::out_item_t got);
    dbd_pkg::out_item_t exp_box;
    if (expected_boxes.size() == 0) begin
      $error("box popped with none expected: x %0d y %0d", got.box_x, got.box_y);
      errors++;
    end else begin
      exp_box = expected_boxes.pop_front();
      if (got.box_x !== exp_box.box_x) begin
        $error("box_x: expected %0d, got %0d", exp_box.box_x, got.box_x);
        errors++;
      end
      if (got.box_y !== exp_box.box_y) begin
        $error("box_y: expected %0d, got %0d", exp_box.box_y, got.box_y);
        errors++;
      end
      if (got.box_width !== exp_box.box_width) begin
        $error("box_width: expected %0d, got %0d", exp_box.box_width, got.box_width);
        errors++;
      end
      if (got.box_height !== exp_box.box_height) begin
        $error("box_height: expected %0d, got %0d", exp_box.box_height, got.box_height);
        errors++;
      end
      if (got.class_index !== exp_box.class_index) begin
        $error("class_index: expected %0d, got %0d", exp_box.class_index, got.class_index);
        errors++;
      end
      if (got.best_score_out !== exp_box.best_score_out) begin
        $error("best_score_out: expected %0d, got %0d", exp_box.best_score_out,
               got.best_score_out);
        errors++;
      end
    end
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(11, 40);
  endfunction

  // sender: hold while full, advance on each beat
  always @(posedge clk) begin
    if (!rst_n) begin
      in_push <= 1'b0;
      tx_gap = 0;
    end else begin
      if (in_push && !in_full) begin
        decode_element(in_data);
        tx_gap = tx_idle_on ? pick_gap() : 0;
      end
      if (in_push && in_full) begin
      end else if (tx_gap > 0) begin
        tx_gap--;
        in_push <= 1'b0;
      end else if (element_queue.size() > 0) begin
        in_push <= 1'b1;
        in_data <= element_queue.pop_front();
      end else begin
        in_push <= 1'b0;
      end
    end
  end

  // receiver: check each beat, then decide on the next pop
  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
      rx_gap = 0;
      hold_left = 0;
    end else begin
      if (out_pop && !out_empty) check_box(out_data);
      if (hold_left > 0) begin
        hold_left--;
        out_pop <= 1'b0;
      end else if (hold_served < hold_requests) begin
        hold_served++;
        hold_left = RX_HOLD_CYCLES;
        out_pop <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        out_pop <= 1'b0;
      end else begin
        out_pop <= 1'b1;
        rx_gap = rx_idle_on ? pick_gap() : 0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty) || cfg_wr_en) begin
      idle_run <= 0;
    end else if (idle_run >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_run <= idle_run + 1;
    end
  end

  function automatic void put(input int v, input bit last);
    dbd_pkg::in_item_t it;
    it.element_value = 20'(v);
    it.last_element  = last;
    element_queue = {element_queue, it};
  endfunction

  function automatic int rand_score();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(0, 300);
    if (r < 90) return $urandom_range(0, 8192);
    return int'($urandom());
  endfunction

  function automatic int rand_coord();
    return int'($urandom_range(0, 700 * 256)) - 30 * 256;
  endfunction

  function automatic int add_prediction();
    int kind, len, nscores;
    kind = $urandom_range(0, 99);
    if (kind < 6) begin
      len = $urandom_range(1, 12);
      for (int i = 0; i < len; i++)
        put(int'($urandom()), (i == len - 1) ? 1'b1 : 1'($urandom_range(0, 1)));
      return len;
    end
    if (kind < 12) begin
      len = $urandom_range(1, dbd_pkg::BOX_ELEMENTS);
      for (int i = 0; i < len; i++) put(rand_coord(), i == len - 1);
      return len;
    end
    kind = $urandom_range(0, 99);
    if (kind < 85) nscores = $urandom_range(1, 6);
    else if (kind < 97) nscores = $urandom_range(7, 40);
    else nscores = $urandom_range(MAX_CLASSES - 2, MAX_CLASSES + 10);
    put(rand_coord(), 1'b0);
    put(rand_coord(), 1'b0);
    put($urandom_range(1, 700 * 256), 1'b0);
    put($urandom_range(1, 700 * 256), 1'b0);
    for (int i = 0; i < nscores; i++) put(rand_score(), i == nscores - 1);
    return dbd_pkg::BOX_ELEMENTS + nscores;
  endfunction

  task automatic cfg_write(input logic [dbd_pkg::CFG_IDX_W-1:0] idx,
                           input logic [dbd_pkg::CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      dbd_pkg::CFG_IDX_THRESHOLD:    thr_cfg   = val[8:0];
      dbd_pkg::CFG_IDX_IMAGE_WIDTH:  img_w_cfg = val;
      dbd_pkg::CFG_IDX_IMAGE_HEIGHT: img_h_cfg = val;
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    while (element_queue.size() != 0 || in_push || expected_boxes.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(input logic [8:0] thr, input logic [12:0] iw, input logic [12:0] ih,
                           input int budget, input bit hold, input bit long_pred);
    int added;
    added = 0;
    cfg_write(dbd_pkg::CFG_IDX_THRESHOLD, dbd_pkg::CFG_DATA_W'(thr));
    cfg_write(dbd_pkg::CFG_IDX_IMAGE_WIDTH, iw);
    cfg_write(dbd_pkg::CFG_IDX_IMAGE_HEIGHT, ih);
    tx_idle_on = hold ? 1'b0 : ($urandom_range(0, 3) != 0);
    rx_idle_on = hold ? 1'b0 : ($urandom_range(0, 3) != 0);
    if (hold) hold_requests++;
    if (long_pred) begin
      put(320 * 256, 1'b0);
      put(320 * 256, 1'b0);
      put(100 * 256, 1'b0);
      put(100 * 256, 1'b0);
      for (int i = 0; i < POS_MAX + 1; i++)
        put((i == MAX_CLASSES - 1) ? 250 : (i == MAX_CLASSES + 20) ? 400 :
            $urandom_range(0, 200), i == POS_MAX);
    end
    while (added < budget) added += add_prediction();
    wait_idle();
  endtask

  initial begin
    thr_cfg    = dbd_pkg::THRESHOLD_RESET;
    img_w_cfg  = dbd_pkg::IMAGE_SIZE_RESET;
    img_h_cfg  = dbd_pkg::IMAGE_SIZE_RESET;
    elem_pos   = '0;
    cx_q       = '0;
    cy_q       = '0;
    w_q        = '0;
    h_q        = '0;
    best_score = '0;
    best_class = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // corner beyond the image, full-scale score
    put(524287, 1'b0); put(524287, 1'b0); put(524287, 1'b0); put(524287, 1'b0);
    put(524287, 1'b1);
    // most negative centre, tied scores keep the first, negative score
    put(-524288, 1'b0); put(-524288, 1'b0); put(524287, 1'b0); put(524287, 1'b0);
    put(129, 1'b0); put(129, 1'b0); put(-524288, 1'b1);
    // last before any score
    put(81920, 1'b0); put(81920, 1'b1);
    // score equal to threshold
    put(81920, 1'b0); put(81920, 1'b0); put(25600, 1'b0); put(25600, 1'b0);
    put(128, 1'b1);
    // zero width
    put(81920, 1'b0); put(81920, 1'b0); put(0, 1'b0); put(25600, 1'b0);
    put(256, 1'b1);
    wait_idle();

    run_phase(9'd0,   13'd1,    13'd1,    80,  1'b0, 1'b0);
    run_phase(9'd256, 13'd4096, 13'd4096, 100, 1'b0, 1'b0);
    run_phase(9'd511, 13'd8191, 13'd8191, 80,  1'b0, 1'b0);
    run_phase(9'd100, 13'd1920, 13'd1080, 300, 1'b1, 1'b0);
    run_phase(9'd0,   13'd0,    13'd480,  60,  1'b0, 1'b0);
    run_phase(9'd200, 13'd4095, 13'd1,    80,  1'b0, 1'b0);
    run_phase(9'd128, 13'd640,  13'd640,  80,  1'b0, 1'b1);
    for (int p = 0; p < 4; p++)
      run_phase(9'($urandom_range(0, 300)), 13'($urandom_range(1, 4200)),
                13'($urandom_range(1, 4200)), 80, 1'b0, 1'b0);

    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
